FILE: rtl/ipv4rf_pkg.sv
`timescale 1ns / 1ps

package ipv4rf_pkg;

   localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [15:0] BYTE_COUNT_MAX   = 16'hFFFF;
   localparam logic [7:0]  PROTO_ICMP       = 8'd1;
   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [7:0]  BROADCAST_OCTET  = 8'd255;
   localparam logic [3:0]  IP_VERSION       = 4'd4;

   localparam logic [15:0] POS_VERSION_IHL  = 16'd0;
   localparam logic [15:0] POS_LENGTH_HI    = 16'd2;
   localparam logic [15:0] POS_LENGTH_LO    = 16'd3;
   localparam logic [15:0] POS_PROTOCOL     = 16'd9;
   localparam logic [15:0] POS_SOURCE_0     = 16'd12;
   localparam logic [15:0] POS_SOURCE_1     = 16'd13;
   localparam logic [15:0] POS_SOURCE_2     = 16'd14;
   localparam logic [15:0] POS_SOURCE_3     = 16'd15;
   localparam logic [15:0] POS_DEST_0       = 16'd16;
   localparam logic [15:0] POS_DEST_1       = 16'd17;
   localparam logic [15:0] POS_DEST_2       = 16'd18;
   localparam logic [15:0] POS_DEST_3       = 16'd19;

   typedef enum logic [2:0] {
      VERDICT_ICMP        = 3'd0,
      VERDICT_TCP         = 3'd1,
      VERDICT_SHORT       = 3'd2,
      VERDICT_BAD_VERSION = 3'd3,
      VERDICT_SHORT_HDR   = 3'd4,
      VERDICT_NOT_FOR_US  = 3'd5,
      VERDICT_OTHER_PROTO = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] source_address;
      logic [5:0]  header_length;
      logic [15:0] payload_length;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [7:0]  version_and_ihl;
      logic [15:0] datagram_length;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
   } fields_type;

endpackage

FILE: rtl/ipv4rf_capture.sv
`timescale 1ns / 1ps

module ipv4rf_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  ipv4rf_pkg::req_payload_type beat,
   output ipv4rf_pkg::fields_type fields_next
);
   import ipv4rf_pkg::*;

   fields_type fields_ff;
   fields_type fields_in;
   logic [15:0] pos;

   assign pos = fields_ff.byte_count;

   always_comb begin
      fields_in = fields_ff;
      if (fields_ff.byte_count != BYTE_COUNT_MAX) begin
         fields_in.byte_count = fields_ff.byte_count + 16'd1;
      end
      unique case (pos)
         POS_VERSION_IHL: fields_in.version_and_ihl = beat.data_byte;
         POS_LENGTH_HI:   fields_in.datagram_length[15:8] = beat.data_byte;
         POS_LENGTH_LO:   fields_in.datagram_length[7:0] = beat.data_byte;
         POS_PROTOCOL:    fields_in.protocol = beat.data_byte;
         POS_SOURCE_0:    fields_in.source[31:24] = beat.data_byte;
         POS_SOURCE_1:    fields_in.source[23:16] = beat.data_byte;
         POS_SOURCE_2:    fields_in.source[15:8] = beat.data_byte;
         POS_SOURCE_3:    fields_in.source[7:0] = beat.data_byte;
         POS_DEST_0:      fields_in.destination[31:24] = beat.data_byte;
         POS_DEST_1:      fields_in.destination[23:16] = beat.data_byte;
         POS_DEST_2:      fields_in.destination[15:8] = beat.data_byte;
         POS_DEST_3:      fields_in.destination[7:0] = beat.data_byte;
         default: ;
      endcase
   end

   assign fields_next = fields_in;

   // The last beat of a packet returns all packet state to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff <= '0;
      end else if (beat_valid) begin
         if (beat.last_byte) begin
            fields_ff <= '0;
         end else begin
            fields_ff <= fields_in;
         end
      end
   end

endmodule

FILE: rtl/ipv4rf_classify.sv
`timescale 1ns / 1ps

module ipv4rf_classify (
   input  ipv4rf_pkg::fields_type      fields,
   input  logic [31:0]                 local_address,
   output ipv4rf_pkg::rsp_payload_type result
);
   import ipv4rf_pkg::*;

   logic [5:0]  header_length;
   verdict_type verdict;

   assign header_length = {fields.version_and_ihl[3:0], 2'b00};

   always_comb begin
      priority if (fields.byte_count < MIN_HEADER_BYTES) begin
         verdict = VERDICT_SHORT;
      end else if (fields.version_and_ihl[7:4] != IP_VERSION) begin
         verdict = VERDICT_BAD_VERSION;
      end else if (fields.byte_count < {10'd0, header_length}) begin
         verdict = VERDICT_SHORT_HDR;
      end else if (fields.destination != local_address &&
                   fields.destination[7:0] != BROADCAST_OCTET) begin
         verdict = VERDICT_NOT_FOR_US;
      end else if (fields.protocol == PROTO_ICMP) begin
         verdict = VERDICT_ICMP;
      end else if (fields.protocol == PROTO_TCP) begin
         verdict = VERDICT_TCP;
      end else begin
         verdict = VERDICT_OTHER_PROTO;
      end
   end

   assign result.verdict        = verdict;
   assign result.source_address = fields.source;
   assign result.header_length  = header_length;
   assign result.payload_length = fields.datagram_length - {10'd0, header_length};

endmodule

FILE: rtl/ipv4_receive_filter_unit.sv
`timescale 1ns / 1ps
// The last byte of a packet is held in the input register; its verdict is written to the
// result register once that register is free. Throughput: one byte per cycle, but a last
// byte waits while a verdict is stalled; the input register and the result register let a
// new byte enter while a finished verdict waits on a stalled result channel. Reset is
// synchronous and clears the packet state, the local address and both valid flags.

module ipv4_receive_filter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ipv4rf_pkg::req_payload_type req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ipv4rf_pkg::rsp_payload_type rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [31:0]                 csr_data
);
   import ipv4rf_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_beat_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic [31:0]     local_address_ff;

   logic            advance;
   logic            rsp_free;
   fields_type      fields_next;
   rsp_payload_type result;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_beat_ff.last_byte || rsp_free);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ipv4rf_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (advance),
      .beat        (in_beat_ff),
      .fields_next (fields_next)
   );

   ipv4rf_classify u_classify (
      .fields        (fields_next),
      .local_address (local_address_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_beat_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance && in_beat_ff.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && advance && in_beat_ff.last_byte) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         local_address_ff <= csr_data;
      end
   end

endmodule
